// ===== src/sscpm_pkg.sv =====
// ----------------------------------------------------------------------------
// sscpm_pkg
// Shared types and constants for the stereo scope capture and peak meter.
// ----------------------------------------------------------------------------
package sscpm_pkg;

    // Command codes carried by one input item
    typedef enum logic [1:0] {
        OP_FRAME      = 2'd0,
        OP_READ_RING  = 2'd1,
        OP_READ_LEVEL = 2'd2,
        OP_CLEAR      = 2'd3
    } t_opcode;

    // Control sequencer states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SCALE = 1'b1
    } t_state;

    // Register indexes on the configuration port
    localparam logic REG_DECAY = 1'b0;

    // Reset value of the decay factor, Q0.16 (about 0.9)
    localparam logic [15:0] DECAY_RESET = 16'd58982;

    // Output scale factor
    localparam logic signed [27:0] SCALE_MUL = 28'sd1000;

    // Half of one output step in the Q1.15 product remainder
    localparam logic [14:0] ROUND_HALF = 15'h4000;

    // Frame command from the top level to the meter
    typedef struct packed {
        logic               frame;
        logic               last;
        logic               clear;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_meter_cmd;

    // Magnitude of a Q1.15 sample; -32768 gives 32768
    function automatic logic [15:0] mag16(input logic signed [15:0] s);
        logic [15:0] m;
        m = s[15] ? (~s + 16'd1) : s;
        return m;
    endfunction

endpackage

// ===== src/sscpm_ram.sv =====
// ----------------------------------------------------------------------------
// sscpm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sscpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== src/sscpm_meter.sv =====
// ----------------------------------------------------------------------------
// sscpm_meter
// Block peak tracking and per-block level decay for both channels.
// ----------------------------------------------------------------------------
module sscpm_meter import sscpm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_meter_cmd  i_cmd,
    input  logic [15:0] i_decay,
    output logic [15:0] o_level_left,
    output logic [15:0] o_level_right
);

    logic [15:0] r_peak_l, r_peak_r, r_level_l, r_level_r;
    logic [15:0] n_peak_l, n_peak_r, n_level_l, n_level_r;
    logic [15:0] w_mag_l, w_mag_r, w_held_l, w_held_r;
    logic [31:0] w_prod_l, w_prod_r;

    // Fold this frame into the peaks
    always_comb begin
        w_mag_l  = mag16(i_cmd.left);
        w_mag_r  = mag16(i_cmd.right);
        n_peak_l = (w_mag_l > r_peak_l) ? w_mag_l : r_peak_l;
        n_peak_r = (w_mag_r > r_peak_r) ? w_mag_r : r_peak_r;
    end

    // Decay the old levels, truncating the Q0.16 product
    always_comb begin
        w_prod_l  = r_level_l * i_decay;
        w_prod_r  = r_level_r * i_decay;
        w_held_l  = w_prod_l[31:16];
        w_held_r  = w_prod_r[31:16];
        n_level_l = (n_peak_l > w_held_l) ? n_peak_l : w_held_l;
        n_level_r = (n_peak_r > w_held_r) ? n_peak_r : w_held_r;
    end

    // Update peaks and levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_l  <= '0;
            r_peak_r  <= '0;
            r_level_l <= '0;
            r_level_r <= '0;
        end else if (i_cmd.clear) begin
            r_level_l <= '0;
            r_level_r <= '0;
        end else if (i_cmd.frame) begin
            if (i_cmd.last) begin
                r_level_l <= n_level_l;
                r_level_r <= n_level_r;
                r_peak_l  <= '0;
                r_peak_r  <= '0;
            end else begin
                r_peak_l <= n_peak_l;
                r_peak_r <= n_peak_r;
            end
        end
    end

    assign o_level_left  = r_level_l;
    assign o_level_right = r_level_r;

endmodule

// ===== src/sscpm_scale.sv =====
// ----------------------------------------------------------------------------
// sscpm_scale
// Scale a Q1.15 value by 1000, round half to even, register the result.
// ----------------------------------------------------------------------------
module sscpm_scale import sscpm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [16:0] i_value,
    output logic               o_valid,
    output logic signed [10:0] o_value
);

    logic signed [27:0] w_prod;
    logic        [12:0] w_quot;
    logic        [14:0] w_rem;
    logic               w_up;
    logic signed [10:0] n_value;

    // Multiply, then split into floor quotient and remainder of 2^15
    always_comb begin
        w_prod  = $signed({{11{i_value[16]}}, i_value}) * SCALE_MUL;
        w_quot  = w_prod[27:15];
        w_rem   = w_prod[14:0];
        w_up    = (w_rem > ROUND_HALF) || ((w_rem == ROUND_HALF) && w_quot[0]);
        n_value = $signed(w_quot[10:0] + {10'd0, w_up});
    end

    // Strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_en;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_value <= n_value;
        end
    end

endmodule

// ===== src/stereo_scope_capture_peak_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_scope_capture_peak_meter
// Stereo scope capture ring with block peak meter and level decay.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low. A frame item writes both samples
//   into the capture ring and updates the peak meter at the accept edge; a
//   clear item resets the write pointer, fill mark and levels at the accept
//   edge. Neither gives a result.
//   A read item (ring sample or level) runs in order: the ring memory is
//   read at the accept edge, the value is scaled in the next cycle, and the
//   result shows on o_result_valid / o_scaled_value for one cycle after
//   that. busy is high during the scale cycle, so no item is accepted until
//   a read has been scaled; frames and clears run one every cycle while no
//   read is pending. The registered ring memory read sets the scale cycle.
//   A new item may be accepted while a result strobe is showing; the
//   receiver cannot stall.
//   Reset (and clear) leave ring slots unwritten; a fill mark makes them read
//   as zero, so no clearing pass is needed. The decay register resets to
//   58982 (about 0.9); users write it through APB only while idle (unenforced).
//   RING_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module stereo_scope_capture_peak_meter import sscpm_pkg::*; #(
    parameter int RING_DEPTH = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    input  logic               i_last_in_block,
    input  logic               i_channel,
    input  logic [15:0]        i_offset_back,
    // Result channel
    output logic               o_result_valid,
    output logic signed [10:0] o_scaled_value,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    t_state     r_state, n_state;
    t_opcode    w_op;
    t_meter_cmd w_cmd;

    logic [15:0]        r_decay;
    logic [AW-1:0]      r_wp;
    logic               r_wrapped;
    logic               r_rd_ring;
    logic               r_rd_ok;
    logic               r_rd_chan;
    logic [15:0]        r_level;
    logic               w_accept;
    logic               w_frame, w_clear, w_rd_ring, w_rd_level;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;
    logic [15:0]        w_level_l, w_level_r;
    logic [15:0]        w_sample;
    logic signed [16:0] w_value;
    logic               w_scale_en;

    // Decode the accepted item
    always_comb begin
        w_op       = t_opcode'(i_opcode);
        w_accept   = start && !busy;
        w_frame    = w_accept && (w_op == OP_FRAME);
        w_clear    = w_accept && (w_op == OP_CLEAR);
        w_rd_ring  = w_accept && (w_op == OP_READ_RING);
        w_rd_level = w_accept && (w_op == OP_READ_LEVEL);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DECAY)) begin
            r_decay <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DECAY) ? {16'd0, r_decay} : 32'd0;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_rd_ring || w_rd_level) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        busy       = 1'b0;
        w_scale_en = 1'b0;
        case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_SCALE: begin
                busy       = 1'b1;
                w_scale_en = 1'b1;
            end
            default:  busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the write pointer; track whether the ring has been filled once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (w_clear) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (w_frame) begin
            r_wp <= r_wp + AW'(1);
            if (r_wp == LAST_SLOT) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    // Ring read address, offset taken modulo the depth
    assign w_raddr = r_wp - i_offset_back[AW-1:0];

    // Capture the read request for the scale cycle
    always_ff @(posedge i_clk) begin
        if (w_rd_ring || w_rd_level) begin
            r_rd_ring <= w_rd_ring;
            r_rd_ok   <= r_wrapped || (w_raddr < r_wp);
            r_rd_chan <= i_channel;
            r_level   <= i_channel ? w_level_r : w_level_l;
        end
    end

    // Capture ring, left in the upper half
    sscpm_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_frame),
        .i_waddr (r_wp),
        .i_wdata ({i_left_sample, i_right_sample}),
        .i_re    (w_rd_ring),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Peak meter
    always_comb begin
        w_cmd.frame = w_frame;
        w_cmd.last  = i_last_in_block;
        w_cmd.clear = w_clear;
        w_cmd.left  = i_left_sample;
        w_cmd.right = i_right_sample;
    end

    sscpm_meter u_meter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_decay       (r_decay),
        .o_level_left  (w_level_l),
        .o_level_right (w_level_r)
    );

    // Select the value to scale; unwritten slots read as zero
    always_comb begin
        w_sample = r_rd_chan ? w_rdata[15:0] : w_rdata[31:16];
        if (!r_rd_ok) begin
            w_sample = '0;
        end
        w_value = r_rd_ring ? $signed({w_sample[15], w_sample})
                            : $signed({1'b0, r_level});
    end

    sscpm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_scale_en),
        .i_value (w_value),
        .o_valid (o_result_valid),
        .o_value (o_scaled_value)
    );

endmodule
